// File: design/sifb_pkg.sv
// Shared types and constants for the servo instruction frame builder
`timescale 1ns / 1ps
`default_nettype none
package sifb_pkg;

  localparam logic [7:0] SYNC_BYTE         = 8'hFF;
  localparam logic [7:0] LEN_EXTRA         = 8'd2;
  localparam logic [7:0] PROT_LIMIT_RESET  = 8'd5;
  localparam logic [7:0] WRITE_CODE_RESET  = 8'd3;

  localparam int unsigned JQ_DEPTH = 4;
  localparam int unsigned JQ_PTR_W = $clog2(JQ_DEPTH);
  localparam int unsigned JQ_CNT_W = $clog2(JQ_DEPTH + 1);

  typedef enum logic {
    CFG_PROT_LIMIT = 1'b0,
    CFG_WRITE_CODE = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    JOB_HDR,
    JOB_PARAM,
    JOB_REJECT
  } job_kind_e;

  typedef enum logic [2:0] {
    STEP_SYNC0,
    STEP_SYNC1,
    STEP_ID,
    STEP_LEN,
    STEP_INSTR,
    STEP_PARAM,
    STEP_CSUM
  } step_e;

  typedef struct packed {
    job_kind_e  kind;
    logic [7:0] servo_id;
    logic [7:0] len;
    logic [7:0] instr;
    logic [7:0] pb;
    logic       has_pb;
    logic       has_csum;
    logic [7:0] csum;
  } job_t;

endpackage
`default_nettype wire

// File: design/sifb_front.sv
// Front end: item classification, frame tracking and checksum accumulation
`timescale 1ns / 1ps
`default_nettype none
module sifb_front
  import sifb_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire cfg_idx_e   cfg_idx_i,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic       accept_i,
  input  wire logic [7:0] servo_id_i,
  input  wire logic [7:0] instruction_i,
  input  wire logic [7:0] param_count_i,
  input  wire logic [7:0] param_byte_i,
  output logic            job_push_o,
  output job_t            job_o
);

  logic [7:0] prot_limit_q, prot_limit_d;
  logic [7:0] write_code_q, write_code_d;
  logic [7:0] params_left_q, params_left_d;
  logic [7:0] sum_q, sum_d;
  logic       dropping_q, dropping_d;

  logic       idle;
  logic       has_pb;
  logic       reject_hit;
  logic [7:0] len;
  logic [7:0] cnt_m1;
  logic [7:0] left_m1;
  logic [7:0] hdr_sum;
  logic [7:0] prm_sum;

  always_comb begin
    prot_limit_d = prot_limit_q;
    write_code_d = write_code_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PROT_LIMIT: prot_limit_d = cfg_data_i;
        CFG_WRITE_CODE: write_code_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  assign idle       = (params_left_q == 8'd0);
  assign has_pb     = (param_count_i != 8'd0);
  assign len        = 8'(param_count_i + LEN_EXTRA);
  assign cnt_m1     = 8'(param_count_i - 8'd1);
  assign left_m1    = 8'(params_left_q - 8'd1);
  assign reject_hit = has_pb && (instruction_i == write_code_q) &&
                      (param_byte_i < prot_limit_q);
  assign hdr_sum    = 8'(servo_id_i + len + instruction_i + (has_pb ? param_byte_i : 8'd0));
  assign prm_sum    = 8'(sum_q + param_byte_i);

  always_comb begin
    params_left_d   = params_left_q;
    sum_d           = sum_q;
    dropping_d      = dropping_q;
    job_push_o      = 1'b0;
    job_o.kind      = JOB_PARAM;
    job_o.servo_id  = servo_id_i;
    job_o.len       = len;
    job_o.instr     = instruction_i;
    job_o.pb        = param_byte_i;
    job_o.has_pb    = 1'b1;
    job_o.has_csum  = 1'b0;
    job_o.csum      = ~prm_sum;
    if (accept_i) begin
      if (idle && reject_hit) begin
        job_push_o    = 1'b1;
        job_o.kind    = JOB_REJECT;
        params_left_d = cnt_m1;
        dropping_d    = (cnt_m1 != 8'd0);
        sum_d         = 8'd0;
      end else if (idle) begin
        job_push_o     = 1'b1;
        job_o.kind     = JOB_HDR;
        job_o.has_pb   = has_pb;
        params_left_d  = has_pb ? cnt_m1 : 8'd0;
        job_o.has_csum = !has_pb || (cnt_m1 == 8'd0);
        job_o.csum     = ~hdr_sum;
        sum_d          = job_o.has_csum ? 8'd0 : hdr_sum;
        dropping_d     = 1'b0;
      end else if (dropping_q) begin
        params_left_d = left_m1;
        dropping_d    = (left_m1 != 8'd0);
      end else begin
        job_push_o     = 1'b1;
        params_left_d  = left_m1;
        job_o.has_csum = (left_m1 == 8'd0);
        sum_d          = job_o.has_csum ? 8'd0 : prm_sum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prot_limit_q  <= PROT_LIMIT_RESET;
      write_code_q  <= WRITE_CODE_RESET;
      params_left_q <= 8'd0;
      sum_q         <= 8'd0;
      dropping_q    <= 1'b0;
    end else begin
      prot_limit_q  <= prot_limit_d;
      write_code_q  <= write_code_d;
      params_left_q <= params_left_d;
      sum_q         <= sum_d;
      dropping_q    <= dropping_d;
    end
  end

  a_drop_needs_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dropping_q |-> params_left_q != 8'd0)
    else $error("dropping with no parameters left");

  a_idle_sum_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idle |-> sum_q == 8'd0)
    else $error("checksum accumulator not cleared between frames");

  a_drop_no_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && dropping_q) |-> !job_push_o)
    else $error("job issued for a dropped item");

endmodule
`default_nettype wire

// File: design/sifb_jobq.sv
// Job queue between the front end and the byte sequencer
`timescale 1ns / 1ps
`default_nettype none
module sifb_jobq
  import sifb_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t job_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output job_t      job_o
);

  job_t                entries_q [JQ_DEPTH];
  logic [JQ_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [JQ_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [JQ_CNT_W-1:0] count_q, count_d;
  logic                do_push;
  logic                do_pop;

  assign full_o  = (count_q == JQ_CNT_W'(JQ_DEPTH));
  assign valid_o = (count_q != '0);
  assign job_o   = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? JQ_PTR_W'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = do_pop ? JQ_PTR_W'(rd_ptr_q + 1'b1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = JQ_CNT_W'(count_q + 1'b1);
    end else if (do_pop && !do_push) begin
      count_d = JQ_CNT_W'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= JQ_CNT_W'(JQ_DEPTH))
    else $error("job queue count out of range");

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("job pushed into a full queue");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    JQ_PTR_W'(wr_ptr_q - rd_ptr_q) == JQ_PTR_W'(count_q))
    else $error("job queue pointers disagree with count");

endmodule
`default_nettype wire

// File: design/sifb_back.sv
// Back end: expands jobs into frame bytes and holds the output register
`timescale 1ns / 1ps
`default_nettype none
module sifb_back
  import sifb_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       job_valid_i,
  input  wire job_t       job_i,
  output logic            job_pop_o,
  input  wire logic       pop_i,
  output logic            empty_o,
  output logic [7:0]      tx_byte_o,
  output logic            frame_end_o,
  output logic            last_o,
  output logic            rejected_o
);

  step_e      step_q, step_d;
  logic       first_q, first_d;
  step_e      eff;
  step_e      nxt;
  logic       is_rej;
  logic       is_last;
  logic [7:0] byte_sel;
  logic       fire;

  logic       out_valid_q, out_valid_d;
  logic [7:0] byte_q;
  logic       fe_q;
  logic       last_q;
  logic       rej_q;

  assign is_rej = (job_i.kind == JOB_REJECT);
  assign eff    = first_q ? ((job_i.kind == JOB_HDR) ? STEP_SYNC0 : STEP_PARAM) : step_q;
  assign fire   = job_valid_i && (!out_valid_q || pop_i);

  always_comb begin
    byte_sel = 8'd0;
    is_last  = 1'b0;
    nxt      = STEP_CSUM;
    unique case (eff)
      STEP_SYNC0: begin
        byte_sel = SYNC_BYTE;
        nxt      = STEP_SYNC1;
      end
      STEP_SYNC1: begin
        byte_sel = SYNC_BYTE;
        nxt      = STEP_ID;
      end
      STEP_ID: begin
        byte_sel = job_i.servo_id;
        nxt      = STEP_LEN;
      end
      STEP_LEN: begin
        byte_sel = job_i.len;
        nxt      = STEP_INSTR;
      end
      STEP_INSTR: begin
        byte_sel = job_i.instr;
        is_last  = !job_i.has_pb && !job_i.has_csum;
        nxt      = job_i.has_pb ? STEP_PARAM : STEP_CSUM;
      end
      STEP_PARAM: begin
        byte_sel = job_i.pb;
        is_last  = !job_i.has_csum;
      end
      STEP_CSUM: begin
        byte_sel = job_i.csum;
        is_last  = 1'b1;
      end
      default: begin
        is_last = 1'b1;
      end
    endcase
    if (is_rej) begin
      byte_sel = 8'd0;
      is_last  = 1'b1;
    end
  end

  assign job_pop_o = fire && is_last;

  always_comb begin
    step_d      = step_q;
    first_d     = first_q;
    out_valid_d = out_valid_q;
    if (pop_i && out_valid_q) begin
      out_valid_d = 1'b0;
    end
    if (fire) begin
      out_valid_d = 1'b1;
      first_d     = is_last;
      step_d      = nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_SYNC0;
      first_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      byte_q <= byte_sel;
      fe_q   <= is_rej || (eff == STEP_CSUM);
      last_q <= is_last;
      rej_q  <= is_rej;
    end
  end

  assign empty_o     = !out_valid_q;
  assign tx_byte_o   = byte_q;
  assign frame_end_o = fe_q;
  assign last_o      = last_q;
  assign rejected_o  = rej_q;

  a_rej_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && rej_q) |-> (byte_q == 8'd0 && fe_q && last_q))
    else $error("malformed rejection result");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && fe_q) |-> last_q)
    else $error("frame end not marked last");

  a_mid_job_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !first_q |-> job_valid_i)
    else $error("job left the queue before its last byte");

endmodule
`default_nettype wire

// File: design/servo_instruction_frame_builder.sv
// Top level of the servo instruction frame builder
//
//   channel   direction  transfer when          payload
//   input     in         push && !full         servo_id_i, instruction_i,
//                                              param_count_i, param_byte_i
//   result    out        pop && !empty         tx_byte_o, frame_end_o, last_o, rejected_o
//   config    in         cfg_we_i              cfg_idx_i, cfg_data_i
//
// One input item is taken per cycle while the four-entry job queue has room.
// The byte sequencer emits one result byte per cycle unless the result side stalls:
// a frame's first item yields six or seven bytes, a parameter item one or two,
// a rejection one. The first result of an item is registered in the job queue
// and then in the output register before it reaches the result ports.
// Reset clears control state only; there is no clearing pass.
// A stalled result side fills the job queue, which then raises full.
`timescale 1ns / 1ps
`default_nettype none
module servo_instruction_frame_builder
  import sifb_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire cfg_idx_e   cfg_idx_i,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] servo_id_i,
  input  wire logic [7:0] instruction_i,
  input  wire logic [7:0] param_count_i,
  input  wire logic [7:0] param_byte_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      tx_byte_o,
  output logic            frame_end_o,
  output logic            last_o,
  output logic            rejected_o
);

  logic accept;
  logic job_push;
  job_t job_in;
  logic job_pop;
  logic job_valid;
  job_t job_head;

  assign accept = push && !full;

  sifb_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .accept_i      (accept),
    .servo_id_i    (servo_id_i),
    .instruction_i (instruction_i),
    .param_count_i (param_count_i),
    .param_byte_i  (param_byte_i),
    .job_push_o    (job_push),
    .job_o         (job_in)
  );

  sifb_jobq u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (job_pop),
    .valid_o (job_valid),
    .job_o   (job_head)
  );

  sifb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job_head),
    .job_pop_o   (job_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .tx_byte_o   (tx_byte_o),
    .frame_end_o (frame_end_o),
    .last_o      (last_o),
    .rejected_o  (rejected_o)
  );

endmodule
`default_nettype wire
